>>> hdl/gcsp_pkg.sv
package gcsp_pkg;

    // Table geometry default; the top level carries it as a parameter.
    localparam int TABLE_SLOTS_DEF = 2048;

    // Atlas geometry (fixed by the port widths of the atlas fields).
    localparam int ATLAS_COLUMNS    = 512;
    localparam int ATLAS_START_ROWS = 256;
    localparam int ATLAS_MAX_ROWS   = 4096;
    localparam int FONT_SLOTS       = 8;
    localparam int PAD_CELLS        = 1;

    // Stored key: (font + 1) in 4 bits, size in 16 bits, codepoint in 21 bits.
    localparam int KEY_W = 41;

    localparam logic [63:0] HASH_MULT = 64'd1099511628211;

    typedef enum logic [1:0] {
        STATUS_HIT     = 2'd0,
        STATUS_PLACED  = 2'd1,
        STATUS_ADVANCE = 2'd2,
        STATUS_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic [8:0]  x;
        logic [11:0] y;
        logic [9:0]  w;
        logic [12:0] h;
        logic        rendered;
    } place_t;

    typedef struct packed {
        logic        start;
        logic [9:0]  w;
        logic [12:0] h;
    } shelf_cmd_t;

    typedef struct packed {
        logic        done;
        logic        placed;
        logic [8:0]  x;
        logic [11:0] y;
        logic [12:0] rows;
    } shelf_rsp_t;

    // Low 16 bits of key * HASH_MULT. The low bits of a product depend only on
    // the low bits of its operands, and the key's low 16 bits are codepoint bits.
    function automatic logic [15:0] hash_low(input logic [15:0] key_low);
        logic [31:0] prod;
        prod = 32'(key_low) * 32'(HASH_MULT[15:0]);
        return prod[15:0];
    endfunction

endpackage

>>> hdl/gcsp_ram.sv
module gcsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/gcsp_shelf.sv
module gcsp_shelf import gcsp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  shelf_cmd_t cmd,
    output shelf_rsp_t rsp
);

    typedef enum logic [1:0] {
        SH_IDLE = 2'b01,
        SH_GROW = 2'b10
    } sh_state_t;

    localparam logic [10:0] COLS_X     = 11'(ATLAS_COLUMNS);
    localparam logic [12:0] START_ROWS = 13'(ATLAS_START_ROWS);
    localparam logic [12:0] HALF_MAX   = 13'(ATLAS_MAX_ROWS / 2);

    sh_state_t   state_reg, state_next;
    logic [9:0]  col_reg, col_next;
    logic [12:0] row_reg, row_next;
    logic [12:0] sh_reg, sh_next;
    logic [12:0] atlas_reg, atlas_next;
    logic [12:0] rows_reg, rows_next;
    logic [13:0] need_reg, need_next;
    logic [9:0]  w_reg, w_next;
    logic [12:0] h_reg, h_next;

    logic        bad_box;
    logic        wrap;
    logic [12:0] atlas_eff;
    logic [9:0]  col1;
    logic [12:0] row1;
    logic [12:0] sh1;
    logic [13:0] need;
    logic [9:0]  base_col;
    logic [12:0] base_row;
    logic [12:0] base_sh;
    logic [9:0]  use_w;
    logic [12:0] use_h;
    logic [9:0]  col_place;
    logic [13:0] h_pad;
    logic [12:0] sh_place;

    always_comb
    begin
        bad_box   = (cmd.w == '0) || (cmd.h == '0) || ({1'b0, cmd.w} > COLS_X);
        atlas_eff = (atlas_reg == '0) ? START_ROWS : atlas_reg;
        wrap      = ({1'b0, col_reg} + {1'b0, cmd.w}) > COLS_X;
        col1      = wrap ? '0 : col_reg;
        row1      = wrap ? row_reg + sh_reg : row_reg;
        sh1       = wrap ? '0 : sh_reg;
        need      = {1'b0, row1} + {1'b0, cmd.h};

        // Place from the freshly wrapped shelf, or from the stored one after growth.
        if (state_reg == SH_IDLE)
        begin
            base_col = col1;
            base_row = row1;
            base_sh  = sh1;
            use_w    = cmd.w;
            use_h    = cmd.h;
        end
        else
        begin
            base_col = col_reg;
            base_row = row_reg;
            base_sh  = sh_reg;
            use_w    = w_reg;
            use_h    = h_reg;
        end
        col_place = base_col + use_w + 10'(PAD_CELLS);
        h_pad     = {1'b0, use_h} + 14'(PAD_CELLS);
        sh_place  = (h_pad > {1'b0, base_sh}) ? h_pad[12:0] : base_sh;

        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        sh_next    = sh_reg;
        atlas_next = atlas_reg;
        rows_next  = rows_reg;
        need_next  = need_reg;
        w_next     = w_reg;
        h_next     = h_reg;

        rsp.done   = 1'b0;
        rsp.placed = 1'b0;
        rsp.x      = base_col[8:0];
        rsp.y      = base_row[11:0];
        rsp.rows   = atlas_reg;

        unique case (state_reg)
            SH_IDLE:
            begin
                if (cmd.start)
                begin
                    if (bad_box)
                    begin
                        rsp.done = 1'b1;
                    end
                    else
                    begin
                        atlas_next = atlas_eff;
                        col_next   = col1;
                        row_next   = row1;
                        sh_next    = sh1;
                        if (need <= {1'b0, atlas_eff})
                        begin
                            col_next   = col_place;
                            sh_next    = sh_place;
                            rsp.done   = 1'b1;
                            rsp.placed = 1'b1;
                        end
                        else
                        begin
                            rows_next  = atlas_eff;
                            need_next  = need;
                            w_next     = cmd.w;
                            h_next     = cmd.h;
                            state_next = SH_GROW;
                        end
                    end
                end
            end
            SH_GROW:
            begin
                // Double one step per cycle; give up past the row limit.
                if ({1'b0, rows_reg} >= need_reg)
                begin
                    atlas_next = rows_reg;
                    col_next   = col_place;
                    sh_next    = sh_place;
                    rsp.done   = 1'b1;
                    rsp.placed = 1'b1;
                    state_next = SH_IDLE;
                end
                else if (rows_reg > HALF_MAX)
                begin
                    rsp.done   = 1'b1;
                    state_next = SH_IDLE;
                end
                else
                begin
                    rows_next = {rows_reg[11:0], 1'b0};
                end
            end
            default:
            begin
                state_next = SH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SH_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            sh_reg    <= '0;
            atlas_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            sh_reg    <= sh_next;
            atlas_reg <= atlas_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rows_reg <= rows_next;
        need_reg <= need_next;
        w_reg    <= w_next;
        h_reg    <= h_next;
    end

endmodule

>>> hdl/glyph_cache_shelf_packer.sv
// Glyph cache with an open-addressing key table and a shelf-packed atlas.
// Each request carries a font slot, a half-pixel size, a codepoint and the
// glyph's bitmap box; it returns one result: hit, inserted and placed,
// inserted advance-only, or refused because the table is three-quarters full.
// After reset the block sweeps all TABLE_SLOTS slots of the key table (2048 by
// default) to empty, one slot a cycle, and holds req_stall high meanwhile.
// Requests are then handled one at a time: the idle state takes the request,
// the probe state walks the table linearly (the key table's single read port
// checks one slot a cycle), the place state hands a new entry to the shelf
// packer, which doubles the atlas (at most four times) when it has to grow,
// and the done state hands the result to the output register once it is free.
// The output register decouples the result channel, so a new request is taken
// while a finished result still waits on res_stall.
module glyph_cache_shelf_packer import gcsp_pkg::*; #(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [2:0]                     font_index,
    input  logic [15:0]                    size_half_px,
    input  logic [20:0]                    codepoint,
    input  logic [9:0]                     box_width,
    input  logic [12:0]                    box_height,

    output logic                           res_valid,
    input  logic                           res_stall,
    output logic [1:0]                     status,
    output logic [$clog2(TABLE_SLOTS)-1:0] slot_index,
    output logic [8:0]                     atlas_x,
    output logic [11:0]                    atlas_y,
    output logic [9:0]                     glyph_width,
    output logic [12:0]                    glyph_height,
    output logic                           rendered,
    output logic [12:0]                    atlas_rows
);

    localparam int IDX_W      = $clog2(TABLE_SLOTS);
    localparam int LOAD_LIMIT = (TABLE_SLOTS * 3) / 4;
    localparam int PLACE_W    = $bits(place_t);
    localparam logic [IDX_W-1:0] LOAD_LIMIT_C = IDX_W'(LOAD_LIMIT);
    localparam logic [IDX_W-1:0] LAST_IDX     = {IDX_W{1'b1}};

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_PROBE = 5'b00100,
        ST_PLACE = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    // Control registers
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic             start_reg, start_next;
    logic             res_valid_reg, res_valid_next;

    // Request and result payload registers
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] probe_reg, probe_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [9:0]       bw_reg, bw_next;
    logic [12:0]      bh_reg, bh_next;
    status_t          rstat_reg, rstat_next;
    logic [IDX_W-1:0] rslot_reg, rslot_next;
    place_t           rplace_reg, rplace_next;

    // Output registers
    status_t          out_status_reg, out_status_next;
    logic [IDX_W-1:0] out_slot_reg, out_slot_next;
    place_t           out_place_reg, out_place_next;
    logic [12:0]      out_rows_reg, out_rows_next;

    // Memory ports
    logic               key_we;
    logic [IDX_W-1:0]   key_waddr;
    logic [KEY_W-1:0]   key_wdata;
    logic [KEY_W-1:0]   key_rdata;
    logic               place_we;
    place_t             place_wdata;
    logic [PLACE_W-1:0] place_rdata;
    logic [IDX_W-1:0]   rd_addr;

    // Request decode
    logic [2:0]       font_n;
    logic [3:0]       font_p1;
    logic [15:0]      size_n;
    logic [15:0]      hash16;
    logic [IDX_W-1:0] hash_idx;
    logic             key_hit;
    logic             key_empty;

    shelf_cmd_t shelf_cmd;
    shelf_rsp_t shelf_rsp;

    gcsp_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (rd_addr),
        .rdata (key_rdata)
    );

    gcsp_ram #(
        .WIDTH (PLACE_W),
        .DEPTH (TABLE_SLOTS)
    ) u_place_ram (
        .clk   (clk),
        .we    (place_we),
        .waddr (idx_reg),
        .wdata (place_wdata),
        .raddr (rd_addr),
        .rdata (place_rdata)
    );

    assign shelf_cmd.start = start_reg;
    assign shelf_cmd.w     = bw_reg;
    assign shelf_cmd.h     = bh_reg;

    gcsp_shelf u_shelf (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (shelf_cmd),
        .rsp   (shelf_rsp)
    );

    // Fold out-of-range fonts to slot 0 and a zero size to one half pixel.
    assign font_n   = ({1'b0, font_index} >= 4'(FONT_SLOTS)) ? '0 : font_index;
    assign font_p1  = {1'b0, font_n} + 4'd1;
    assign size_n   = (size_half_px == '0) ? 16'd1 : size_half_px;
    assign hash16   = hash_low(codepoint[15:0]);
    assign hash_idx = hash16[IDX_W-1:0];

    // The key never reads as zero once written, so zero marks an empty slot.
    assign key_hit   = (key_rdata == key_reg);
    assign key_empty = (key_rdata == '0);

    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        count_next      = count_reg;
        start_next      = 1'b0;
        res_valid_next  = res_valid_reg && res_stall;
        idx_next        = idx_reg;
        probe_next      = probe_reg;
        key_next        = key_reg;
        bw_next         = bw_reg;
        bh_next         = bh_reg;
        rstat_next      = rstat_reg;
        rslot_next      = rslot_reg;
        rplace_next     = rplace_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_place_next  = out_place_reg;
        out_rows_next   = out_rows_reg;

        key_we      = 1'b0;
        key_waddr   = idx_reg;
        key_wdata   = key_reg;
        place_we    = 1'b0;
        place_wdata = '0;
        rd_addr     = idx_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the key table to empty.
                key_we    = 1'b1;
                key_waddr = clr_reg;
                key_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    key_next   = {font_p1, size_n, codepoint};
                    bw_next    = box_width;
                    bh_next    = box_height;
                    idx_next   = hash_idx;
                    rd_addr    = hash_idx;
                    probe_next = '0;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (key_hit)
                begin
                    rstat_next  = STATUS_HIT;
                    rslot_next  = idx_reg;
                    rplace_next = place_t'(place_rdata);
                    state_next  = ST_DONE;
                end
                else if (key_empty && (count_reg < LOAD_LIMIT_C))
                begin
                    // Claim the empty slot and hand the box to the packer.
                    key_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    rslot_next = idx_reg;
                    start_next = 1'b1;
                    state_next = ST_PLACE;
                end
                else if (key_empty || (probe_reg == LAST_IDX))
                begin
                    rstat_next  = STATUS_FULL;
                    rslot_next  = '0;
                    rplace_next = '0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    // Advance to the next slot; its read lands next cycle.
                    idx_next   = idx_reg + 1'b1;
                    rd_addr    = idx_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                end
            end
            ST_PLACE:
            begin
                if (shelf_rsp.done)
                begin
                    if (shelf_rsp.placed)
                    begin
                        place_wdata.x        = shelf_rsp.x;
                        place_wdata.y        = shelf_rsp.y;
                        place_wdata.w        = bw_reg;
                        place_wdata.h        = bh_reg;
                        place_wdata.rendered = 1'b1;
                        rstat_next           = STATUS_PLACED;
                    end
                    else
                    begin
                        rstat_next = STATUS_ADVANCE;
                    end
                    place_we    = 1'b1;
                    rplace_next = place_wdata;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free.
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next  = 1'b1;
                    out_status_next = rstat_reg;
                    out_slot_next   = rslot_reg;
                    out_place_next  = rplace_reg;
                    out_rows_next   = shelf_rsp.rows;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            start_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            start_reg     <= start_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        probe_reg      <= probe_next;
        key_reg        <= key_next;
        bw_reg         <= bw_next;
        bh_reg         <= bh_next;
        rstat_reg      <= rstat_next;
        rslot_reg      <= rslot_next;
        rplace_reg     <= rplace_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_place_reg  <= out_place_next;
        out_rows_reg   <= out_rows_next;
    end

    assign res_valid    = res_valid_reg;
    assign status       = out_status_reg;
    assign slot_index   = out_slot_reg;
    assign atlas_x      = out_place_reg.x;
    assign atlas_y      = out_place_reg.y;
    assign glyph_width  = out_place_reg.w;
    assign glyph_height = out_place_reg.h;
    assign rendered     = out_place_reg.rendered;
    assign atlas_rows   = out_rows_reg;

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LOAD_LIMIT_C)
        else $error("entry count above load limit");

    a_insert_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE && key_we) |-> key_rdata == '0)
        else $error("insert over an occupied slot");

    a_shelf_done: assert property (@(posedge clk) disable iff (!rst_n)
        shelf_rsp.done |-> state_reg == ST_PLACE)
        else $error("packer finished outside placement");

    a_placed_box: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && status == STATUS_PLACED) |-> (rendered && glyph_width != '0
            && atlas_rows != '0))
        else $error("placed result without atlas space");

endmodule

>>> bench/glyph_cache_checker.sv
module glyph_cache_checker import gcsp_pkg::*; #(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           req_valid,
    input  logic                           req_stall,
    input  logic [2:0]                     font_index,
    input  logic [15:0]                    size_half_px,
    input  logic [20:0]                    codepoint,
    input  logic [9:0]                     box_width,
    input  logic [12:0]                    box_height,

    input  logic                           res_valid,
    input  logic                           res_stall,
    input  logic [1:0]                     status,
    input  logic [$clog2(TABLE_SLOTS)-1:0] slot_index,
    input  logic [8:0]                     atlas_x,
    input  logic [11:0]                    atlas_y,
    input  logic [9:0]                     glyph_width,
    input  logic [12:0]                    glyph_height,
    input  logic                           rendered,
    input  logic [12:0]                    atlas_rows,

    output int                             pending,
    output int                             errors,
    output int                             hit_count,
    output int                             placed_count,
    output int                             advance_count,
    output int                             refused_count,
    output int                             atlas_peak
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_W     = $clog2(TABLE_SLOTS);
    localparam int LOAD_LIMIT = (TABLE_SLOTS * 3) / 4;

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        place_t             place;
        logic [12:0]        rows;
    } glyph_result_t;

    // Shadow copy of the cache and the atlas packer.
    logic [KEY_W-1:0] key_store [TABLE_SLOTS];
    place_t           place_store [TABLE_SLOTS];
    int unsigned      entries;
    int unsigned      shelf_col;
    int unsigned      shelf_row;
    int unsigned      shelf_h;
    int unsigned      atlas_h;

    glyph_result_t    expected_q [$];
    int               result_num;

    function automatic bit grow_atlas(int unsigned need);
        int unsigned rows;
        rows = (atlas_h > 0) ? atlas_h : ATLAS_START_ROWS;
        while (rows < need && rows <= ATLAS_MAX_ROWS)
            rows *= 2;
        if (rows > ATLAS_MAX_ROWS || rows < need)
            return 1'b0;
        atlas_h = rows;
        return 1'b1;
    endfunction

    function automatic bit place_glyph(int unsigned w, int unsigned h,
                                       output int unsigned px, output int unsigned py);
        px = 0;
        py = 0;
        if (w == 0 || h == 0 || w > ATLAS_COLUMNS)
            return 1'b0;
        if (atlas_h == 0 && !grow_atlas(ATLAS_START_ROWS))
            return 1'b0;
        // Open a new shelf when the glyph does not fit on the current one.
        if (shelf_col + w > ATLAS_COLUMNS)
        begin
            shelf_row += shelf_h;
            shelf_col = 0;
            shelf_h   = 0;
        end
        if (shelf_row + h > atlas_h && !grow_atlas(shelf_row + h))
            return 1'b0;
        px = shelf_col;
        py = shelf_row;
        shelf_col += w + PAD_CELLS;
        if (h + PAD_CELLS > shelf_h)
            shelf_h = h + PAD_CELLS;
        return 1'b1;
    endfunction

    function automatic glyph_result_t lookup_glyph(logic [2:0] font, logic [15:0] size,
                                                   logic [20:0] cp, logic [9:0] bw,
                                                   logic [12:0] bh);
        logic [3:0]       font_tag;
        logic [15:0]      size_q;
        logic [63:0]      probe_key;
        logic [63:0]      mixed;
        logic [KEY_W-1:0] tag;
        int unsigned      idx;
        int unsigned      ax;
        int unsigned      ay;
        bit               found;
        glyph_result_t    r;

        font_tag  = (int'(font) >= FONT_SLOTS) ? 4'd1 : 4'(font) + 4'd1;
        size_q    = (size == 16'd0) ? 16'd1 : size;
        probe_key = {12'd0, font_tag, size_q, 11'd0, cp};
        tag       = {font_tag, size_q, cp};
        mixed     = probe_key * HASH_MULT;
        idx       = mixed[SLOT_W-1:0];

        found = 1'b0;
        for (int p = 0; p < TABLE_SLOTS; p++)
        begin
            if (key_store[idx] == tag || key_store[idx] == '0)
            begin
                found = 1'b1;
                break;
            end
            idx = (idx + 1) % TABLE_SLOTS;
        end

        r        = '0;
        r.status = STATUS_FULL;
        if (found && key_store[idx] == tag)
        begin
            r.status = STATUS_HIT;
            r.slot   = SLOT_W'(idx);
            r.place  = place_store[idx];
        end
        else if (found && entries < LOAD_LIMIT)
        begin
            r.slot         = SLOT_W'(idx);
            key_store[idx] = tag;
            entries++;
            if (place_glyph(bw, bh, ax, ay))
            begin
                r.place.x        = 9'(ax);
                r.place.y        = 12'(ay);
                r.place.w        = bw;
                r.place.h        = bh;
                r.place.rendered = 1'b1;
                r.status         = STATUS_PLACED;
            end
            else
                r.status = STATUS_ADVANCE;
            place_store[idx] = r.place;
        end
        r.rows = 13'(atlas_h);
        return r;
    endfunction

    task automatic report_field(string field, int unsigned got, int unsigned want);
        if (got != want)
        begin
            if (errors < 200)
                $display("[%0t] result %0d: %s is %0d, expected %0d",
                         $time, result_num, field, got, want);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        glyph_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                key_store[i]   = '0;
                place_store[i] = '0;
            end
            entries   = 0;
            shelf_col = 0;
            shelf_row = 0;
            shelf_h   = 0;
            atlas_h   = 0;
            expected_q.delete();
            result_num    = 0;
            errors        = 0;
            hit_count     = 0;
            placed_count  = 0;
            advance_count = 0;
            refused_count = 0;
            atlas_peak    = 0;
            pending      <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                result_num++;
                if (expected_q.size() == 0)
                    report_field("unexpected result", 1, 0);
                else
                begin
                    want = expected_q.pop_front();
                    report_field("status", status, want.status);
                    report_field("slot_index", slot_index, want.slot);
                    report_field("atlas_x", atlas_x, want.place.x);
                    report_field("atlas_y", atlas_y, want.place.y);
                    report_field("glyph_width", glyph_width, want.place.w);
                    report_field("glyph_height", glyph_height, want.place.h);
                    report_field("rendered", rendered, want.place.rendered);
                    report_field("atlas_rows", atlas_rows, want.rows);
                    case (want.status)
                        STATUS_HIT:     hit_count++;
                        STATUS_PLACED:  placed_count++;
                        STATUS_ADVANCE: advance_count++;
                        default:        refused_count++;
                    endcase
                    if (int'(want.rows) > atlas_peak)
                        atlas_peak = want.rows;
                end
            end
            if (req_valid && !req_stall)
                expected_q.push_back(lookup_glyph(font_index, size_half_px, codepoint,
                                                  box_width, box_height));
            pending <= expected_q.size();
        end
    end

endmodule

>>> bench/tb_glyph_cache_shelf_packer.sv
module tb_glyph_cache_shelf_packer;
    timeunit 1ns;
    timeprecision 1ps;

    import gcsp_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int SLOT_W           = $clog2(TABLE_SLOTS_DEF);
    localparam int RANDOM_PER_PHASE = 500;
    // Longest fresh insert: a full probe walk plus placement and four doublings.
    localparam int DRAIN_CYCLES     = TABLE_SLOTS_DEF + 16;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              req_valid    = 1'b0;
    logic              res_stall    = 1'b0;
    logic [2:0]        font_index   = '0;
    logic [15:0]       size_half_px = '0;
    logic [20:0]       codepoint    = '0;
    logic [9:0]        box_width    = '0;
    logic [12:0]       box_height   = '0;

    logic              req_stall;
    logic              res_valid;
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot_index;
    logic [8:0]        atlas_x;
    logic [11:0]       atlas_y;
    logic [9:0]        glyph_width;
    logic [12:0]       glyph_height;
    logic              rendered;
    logic [12:0]       atlas_rows;

    int                pending;
    int                errors;
    int                hit_count;
    int                placed_count;
    int                advance_count;
    int                refused_count;
    int                atlas_peak;

    // Idle percentages for the sending and receiving sides of the current phase.
    int                send_idle_pct = 0;
    int                stall_pct     = 0;

    // Every key sent so far, {font, size, codepoint}, for repeat lookups.
    logic [39:0]       sent_keys [$];

    glyph_cache_shelf_packer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .font_index   (font_index),
        .size_half_px (size_half_px),
        .codepoint    (codepoint),
        .box_width    (box_width),
        .box_height   (box_height),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .status       (status),
        .slot_index   (slot_index),
        .atlas_x      (atlas_x),
        .atlas_y      (atlas_y),
        .glyph_width  (glyph_width),
        .glyph_height (glyph_height),
        .rendered     (rendered),
        .atlas_rows   (atlas_rows)
    );

    glyph_cache_checker cache_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .font_index    (font_index),
        .size_half_px  (size_half_px),
        .codepoint     (codepoint),
        .box_width     (box_width),
        .box_height    (box_height),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .status        (status),
        .slot_index    (slot_index),
        .atlas_x       (atlas_x),
        .atlas_y       (atlas_y),
        .glyph_width   (glyph_width),
        .glyph_height  (glyph_height),
        .rendered      (rendered),
        .atlas_rows    (atlas_rows),
        .pending       (pending),
        .errors        (errors),
        .hit_count     (hit_count),
        .placed_count  (placed_count),
        .advance_count (advance_count),
        .refused_count (refused_count),
        .atlas_peak    (atlas_peak)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Receiver back-pressure: redraw the stall every cycle at the phase's rate.
    always @(posedge clk)
        res_stall <= ($urandom_range(99) < stall_pct);

    // Present one request, holding it steady until the block takes it. Any idle
    // cycles go before it, so valid is never dropped and raised in one step.
    task automatic send_glyph(input logic [2:0] font, input logic [15:0] size,
                              input logic [20:0] cp, input logic [9:0] bw,
                              input logic [12:0] bh);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid    <= 1'b1;
        font_index   <= font;
        size_half_px <= size;
        codepoint    <= cp;
        box_width    <= bw;
        box_height   <= bh;
        sent_keys.push_back({font, size, cp});
        do
            @(posedge clk);
        while (req_stall);
    endtask

    initial
    begin
        logic [2:0]  f;
        logic [15:0] sz;
        logic [20:0] cp;
        logic [9:0]  bw;
        logic [12:0] bh;
        int          pick;

        // Hold reset, then release it on a clock edge. The block then sweeps
        // its key table and stalls requests until done.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests, no idling on either side.
        // Zero size folds onto size one, so the second request hits the first.
        send_glyph(3'd0, 16'd0, 21'd0, 10'd0, 13'd0);
        send_glyph(3'd0, 16'd1, 21'd0, 10'd7, 13'd9);
        // Largest key fields with a box wider than the atlas: advance only.
        send_glyph(3'd7, 16'd65535, 21'd1114111, 10'd1023, 13'd4096);
        // Zero height: advance only.
        send_glyph(3'd3, 16'd12, 21'd65, 10'd10, 13'd0);
        // First placement opens the atlas at its starting height.
        send_glyph(3'd3, 16'd12, 21'd66, 10'd10, 13'd16);
        // Full-width glyph forces a new shelf; one column more is too wide.
        send_glyph(3'd3, 16'd12, 21'd67, 10'd512, 13'd20);
        send_glyph(3'd3, 16'd12, 21'd68, 10'd513, 13'd20);
        send_glyph(3'd3, 16'd12, 21'd69, 10'd1, 13'd1);
        // Tall glyphs grow the atlas by one doubling, then by two.
        send_glyph(3'd3, 16'd12, 21'd70, 10'd100, 13'd300);
        send_glyph(3'd3, 16'd12, 21'd71, 10'd50, 13'd1000);
        // Hit on a placed entry; the box on a hit is ignored.
        send_glyph(3'd3, 16'd12, 21'd66, 10'd0, 13'd0);
        // Keys sharing a home slot with codepoint 66: walk the probe chain.
        send_glyph(3'd3, 16'd12, 21'd2114, 10'd8, 13'd8);
        send_glyph(3'd5, 16'd700, 21'd66, 10'd8, 13'd8);
        send_glyph(3'd4, 16'd12, 21'd66, 10'd0, 13'd5);
        send_glyph(3'd5, 16'd700, 21'd66, 10'd1, 13'd1);
        // Hit on an advance-only entry returns an empty placement.
        send_glyph(3'd7, 16'd65535, 21'd1114111, 10'd3, 13'd3);
        // A single set bit in every field, then alternating bit patterns in the size, codepoint and box fields.
        send_glyph(3'd1, 16'd32768, 21'd1048576, 10'd256, 13'd8);
        send_glyph(3'd6, 16'd21845, 21'd699050, 10'd341, 13'd170);
        send_glyph(3'd1, 16'd43690, 21'd349525, 10'd682, 13'd1365);
        // Atlas cannot reach the full height: advance only, atlas unchanged.
        send_glyph(3'd2, 16'd2, 21'd2047, 10'd1, 13'd4096);
        // Same, but after a shelf change, which stays in effect for the next one.
        send_glyph(3'd2, 16'd3, 21'd2046, 10'd512, 13'd4000);
        send_glyph(3'd2, 16'd4, 21'd2045, 10'd30, 13'd30);

        // Random requests in four pacing phases.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 56; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 56; end
                default: begin send_idle_pct = 37; stall_pct = 37; end
            endcase

            // Drain the block completely once before heavy back-pressure.
            if (phase == 2)
            begin
                req_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending != 0);
            end

            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // Key: repeat an old one, crowd two home slots (codepoints that
                // agree in their low 11 bits, so chains grow long), or pick freely.
                pick = $urandom_range(99);
                if (pick < 15)
                    {f, sz, cp} = sent_keys[$urandom_range(sent_keys.size() - 1)];
                else if (pick < 30)
                begin
                    f  = 3'($urandom);
                    sz = 16'($urandom_range(64, 1));
                    cp = 21'(2046 + $urandom_range(1) + 2048 * $urandom_range(542));
                end
                else
                begin
                    f  = 3'($urandom);
                    sz = 16'($urandom);
                    cp = 21'($urandom_range(1114111));
                end

                // Box: mostly small glyphs, with empty, too-wide, wide and
                // tall ones mixed in so the atlas fills and finally runs out.
                pick = $urandom_range(99);
                if (pick < 60)
                begin
                    bw = 10'($urandom_range(24, 1));
                    bh = 13'($urandom_range(40, 1));
                end
                else if (pick < 80)
                begin
                    bw = 10'($urandom_range(160, 1));
                    bh = 13'($urandom_range(64, 1));
                end
                else if (pick < 86)
                begin
                    bw = 10'($urandom_range(1023));
                    bh = 13'($urandom_range(4096));
                    if ($urandom_range(1))
                        bw = '0;
                    else
                        bh = '0;
                end
                else if (pick < 91)
                begin
                    bw = 10'($urandom_range(1023, 513));
                    bh = 13'($urandom_range(4096));
                end
                else if (pick < 97)
                begin
                    bw = 10'($urandom_range(512, 256));
                    bh = 13'($urandom_range(128, 1));
                end
                else
                begin
                    bw = 10'($urandom_range(512, 1));
                    bh = 13'($urandom_range(4096, 65));
                end

                send_glyph(f, sz, cp, bw, bh);
            end
        end

        // Stop sending, wait for every outstanding result, then let the block
        // sit long enough that any stray result would show up.
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d directed and random requests under four pacing phases:",
                 sent_keys.size());
        $display("  %0d hits, %0d placed, %0d advance-only, %0d refused; atlas peak %0d rows",
                 hit_count, placed_count, advance_count, refused_count, atlas_peak);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run (every request walking a
    // full probe chain behind the clearing sweep and the longest stalls).
    initial
    begin
        #200_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
